### design/hcbd_pkg.sv
// Shared constants and result type for the chunked body decoder.
package hcbd_pkg;

	// Framing characters
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	// Register indexes on the configuration port
	localparam logic REG_MAX_BODY_SIZE = 1'b0;

	// Reset value of the body size limit
	localparam logic [31:0] MAX_BODY_SIZE_RST = 32'd1048576;

	// One result item
	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic        body_done;
		logic        parse_error;
		logic [31:0] body_length;
	} hcbd_result_t;

endpackage

### design/hcbd_parser.sv
// Chunk framing state machine: state registers and the per-item next-state logic.
module hcbd_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic                 new_message,
	input  logic [31:0]          max_body_size,
	output hcbd_pkg::hcbd_result_t result
);
	import hcbd_pkg::*;

	typedef enum logic [3:0] {
		PH_SIZE    = 4'd0,
		PH_SIZE_LF = 4'd1,
		PH_EXT     = 4'd2,
		PH_EXT_CR  = 4'd3,
		PH_DATA    = 4'd4,
		PH_DATA_CR = 4'd5,
		PH_DATA_LF = 4'd6,
		PH_LAST    = 4'd7,
		PH_LAST_LF = 4'd8,
		PH_TRAILER = 4'd9,
		PH_DONE    = 4'd10,
		PH_ERROR   = 4'd11
	} phase_t;

	// Hex digit decode: bit 4 set when the byte is a hex digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, c[3:0]};
		else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

	phase_t      phase_q, phase_d, cur_phase;
	logic [31:0] chunk_rem_q, chunk_rem_d, cur_rem;
	logic [31:0] body_count_q, body_count_d, cur_count;
	logic        saw_digit_q, saw_digit_d, cur_saw;
	logic [1:0]  trailer_match_q, trailer_match_d, cur_tm;
	logic [4:0]  hex;
	logic [32:0] body_sum;
	logic        over_limit;
	phase_t      line_done_phase;
	logic [31:0] rem_dec;
	logic [7:0]  trailer_char;

	// State as seen by this item, after an optional restart
	always_comb begin
		cur_phase = new_message ? PH_SIZE : phase_q;
		cur_rem   = new_message ? 32'd0 : chunk_rem_q;
		cur_count = new_message ? 32'd0 : body_count_q;
		cur_saw   = new_message ? 1'b0 : saw_digit_q;
		cur_tm    = new_message ? 2'd0 : trailer_match_q;
	end

	// Size line complete: last chunk, size limit check, or data
	assign body_sum   = {1'b0, cur_count} + {1'b0, cur_rem};
	assign over_limit = body_sum > {1'b0, max_body_size};
	always_comb begin
		if (cur_rem == 32'd0)
			line_done_phase = PH_LAST;
		else if (over_limit)
			line_done_phase = PH_ERROR;
		else
			line_done_phase = PH_DATA;
	end

	assign hex          = hex_decode(data_byte);
	assign rem_dec      = cur_rem - 32'd1;
	assign trailer_char = cur_tm[0] ? CH_LF : CH_CR;

	// Next state and result for one item
	always_comb begin
		phase_d         = cur_phase;
		chunk_rem_d     = cur_rem;
		body_count_d    = cur_count;
		saw_digit_d     = cur_saw;
		trailer_match_d = cur_tm;
		result          = '0;
		case (cur_phase)
			PH_SIZE: begin
				if (hex[4]) begin
					saw_digit_d = 1'b1;
					if (cur_rem > 32'h0FFF_FFFF)
						chunk_rem_d = 32'hFFFF_FFFF;
					else
						chunk_rem_d = {cur_rem[27:0], hex[3:0]};
				end else if (data_byte == CH_SEMI && cur_saw) begin
					phase_d = PH_EXT;
				end else if (data_byte == CH_CR && cur_saw) begin
					phase_d = PH_SIZE_LF;
				end else begin
					phase_d = PH_ERROR;
				end
			end
			PH_SIZE_LF: begin
				phase_d = (data_byte == CH_LF) ? line_done_phase : PH_ERROR;
			end
			PH_EXT: begin
				if (data_byte == CH_CR)
					phase_d = PH_EXT_CR;
			end
			PH_EXT_CR: begin
				if (data_byte == CH_LF)
					phase_d = line_done_phase;
				else if (data_byte != CH_CR)
					phase_d = PH_EXT;
			end
			PH_DATA: begin
				result.payload_byte  = data_byte;
				result.payload_valid = 1'b1;
				body_count_d         = cur_count + 32'd1;
				chunk_rem_d          = rem_dec;
				if (rem_dec == 32'd0)
					phase_d = PH_DATA_CR;
			end
			PH_DATA_CR: begin
				phase_d = (data_byte == CH_CR) ? PH_DATA_LF : PH_ERROR;
			end
			PH_DATA_LF: begin
				if (data_byte == CH_LF) begin
					phase_d     = PH_SIZE;
					saw_digit_d = 1'b0;
					chunk_rem_d = 32'd0;
				end else begin
					phase_d = PH_ERROR;
				end
			end
			PH_LAST: begin
				if (data_byte == CH_CR) begin
					phase_d = PH_LAST_LF;
				end else begin
					phase_d         = PH_TRAILER;
					trailer_match_d = 2'd0;
				end
			end
			PH_LAST_LF: begin
				if (data_byte == CH_LF) begin
					phase_d          = PH_DONE;
					result.body_done = 1'b1;
				end else begin
					phase_d         = PH_TRAILER;
					trailer_match_d = (data_byte == CH_CR) ? 2'd1 : 2'd0;
				end
			end
			PH_TRAILER: begin
				// looking for CRLFCRLF
				if (data_byte == trailer_char) begin
					if (cur_tm == 2'd3) begin
						phase_d          = PH_DONE;
						result.body_done = 1'b1;
						trailer_match_d  = 2'd0;
					end else begin
						trailer_match_d = cur_tm + 2'd1;
					end
				end else begin
					trailer_match_d = (data_byte == CH_CR) ? 2'd1 : 2'd0;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_ERROR;
			end
		endcase
		result.parse_error = (phase_d == PH_ERROR);
		result.body_length = body_count_d;
	end

	// State registers, updated on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_SIZE;
			chunk_rem_q     <= 32'd0;
			body_count_q    <= 32'd0;
			saw_digit_q     <= 1'b0;
			trailer_match_q <= 2'd0;
		end else if (step) begin
			phase_q         <= phase_d;
			chunk_rem_q     <= chunk_rem_d;
			body_count_q    <= body_count_d;
			saw_digit_q     <= saw_digit_d;
			trailer_match_q <= trailer_match_d;
		end
	end

	// Error is sticky until a restart
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !new_message && phase_q == PH_ERROR) |=> (phase_q == PH_ERROR))
		else $error("error phase left without restart");

	// Data phase always holds a non-zero remaining count
	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (chunk_rem_q != 32'd0))
		else $error("data phase with nothing remaining");

	// Done phase holds its counters
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !new_message && phase_q == PH_DONE) |=> $stable(body_count_q))
		else $error("body count moved after done");

endmodule

### design/http_chunked_body_decoder.sv
// Top level of the chunked body decoder: handshakes, register port and result register.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------------
//  input    | in_valid / in_ready       | data_byte, new_message
//  output   | out_valid / out_ready     | payload_byte, payload_valid, body_done,
//           |                           | parse_error, body_length
//  config   | psel/penable/pwrite/pready| paddr, pwdata, prdata (max_body_size at 0x0)
//
// One item per cycle while the output is taken: each byte is decoded in the cycle it
// is accepted and its result is registered in the output register for the next cycle.
// The limit on rate is the single state update per byte in the framing machine.
// Reset (arst_n low) returns the parser to the size digits and the limit to 1 MiB.
// in_ready is high while the result register is empty or being taken, so a stall
// on the output side holds one result and stops input only then.
module http_chunked_body_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        new_message,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  payload_byte,
	output logic        payload_valid,
	output logic        body_done,
	output logic        parse_error,
	output logic [31:0] body_length,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hcbd_pkg::*;

	logic         limit_sel;
	logic [31:0]  max_body_q;
	logic         step;
	logic         out_valid_q;
	hcbd_result_t result;
	hcbd_result_t result_q;

	// Register port: one register, always ready
	assign pready = 1'b1;
	assign limit_sel = (paddr[2] == REG_MAX_BODY_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q <= MAX_BODY_SIZE_RST;
		end else if (psel && penable && pwrite && limit_sel) begin
			max_body_q <= pwdata;
		end
	end

	assign prdata = limit_sel ? max_body_q : 32'd0;

	// Input handshake
	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	hcbd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.data_byte     (data_byte),
		.new_message   (new_message),
		.max_body_size (max_body_q),
		.result        (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			result_q <= result;
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = result_q.payload_byte;
	assign payload_valid = result_q.payload_valid;
	assign body_done     = result_q.body_done;
	assign parse_error   = result_q.parse_error;
	assign body_length   = result_q.body_length;

	// A data byte never carries an error or the end of body
	a_payload_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(payload_valid && (parse_error || body_done)))
		else $error("payload item flagged as error or done");

	// Every accepted item yields a result next cycle
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid)
		else $error("accepted item produced no result");

	// A held result is never overwritten without a new item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(result_q)))
		else $error("stalled result changed");

endmodule
